// ===== rtl/mlcfd_pkg.sv =====
// ----------------------------------------------------------------------------
// mlcfd_pkg
// Shared constants, types and helpers for the framed packet deframer.
// ----------------------------------------------------------------------------
package mlcfd_pkg;

    localparam int BUFFER_BYTES = 64;
    localparam int ADDR_W       = $clog2(BUFFER_BYTES);
    localparam int FILL_W       = $clog2(BUFFER_BYTES + 1);
    // offsets and frame sizes (LEN + 5) share one width
    localparam int IDX_W        = (FILL_W > 9) ? FILL_W : 9;
    localparam int LEN_CAP      = BUFFER_BYTES - 5;

    localparam logic [7:0]  MAGIC_FIRST  = 8'hA5;
    localparam logic [7:0]  MAGIC_SECOND = 8'h5A;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;
    localparam int          HEADER_LEN   = 3;
    localparam int          CRC_LEN      = 2;
    localparam logic [5:0]  MAX_PAYLOAD_RST = 6'd59;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_BAD_LEN = 2'd2,
        KIND_BAD_CRC = 2'd3
    } t_kind;

    // CRC16-Modbus update over one byte, reflected
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) c = (c >> 1) ^ CRC_POLY;
            else      c = c >> 1;
        end
        return c;
    endfunction

    // circular index: head + off, with off no larger than the store depth
    function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] head,
                                                   input logic [FILL_W-1:0] off);
        logic [FILL_W:0] sum;
        sum = {{(FILL_W + 1 - ADDR_W){1'b0}}, head} + {1'b0, off};
        if (sum >= (FILL_W + 1)'(BUFFER_BYTES)) sum = sum - (FILL_W + 1)'(BUFFER_BYTES);
        return sum[ADDR_W-1:0];
    endfunction

endpackage

// ===== rtl/mlcfd_store.sv =====
// ----------------------------------------------------------------------------
// mlcfd_store
// Receive byte store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mlcfd_store (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [mlcfd_pkg::ADDR_W-1:0] i_waddr,
    input  logic [7:0]                  i_wdata,
    input  logic [mlcfd_pkg::ADDR_W-1:0] i_raddr,
    output logic [7:0]                  o_rdata
);
    import mlcfd_pkg::*;

    logic [7:0] r_mem [BUFFER_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/magic_len_crc16_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// magic_len_crc16_frame_deframer
// Frame hunter for A5 5A | LEN | payload | CRC16-Modbus (low byte first).
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry one received byte per transfer.
// The block takes a byte only when idle, stores it if the store has room,
// then drains the store with one sequencer and one store read port: each
// store read takes an address state and a registered-data state. The magic
// hunt reads every held byte when no magic pair is held, two when one heads
// the store, then LEN once it is held. A byte that completes a frame of LEN
// bytes leads to a CRC pass over LEN and payload, reads of the received CRC
// and payload readout (one marker item for an empty frame), then a new hunt
// over what is left. Each error event emits one marker item and rescans.
// Output channel: o_valid / i_stall, one result item per transfer, from a
// single output register; the sequencer waits on it while the receiver
// stalls, so a stalled output holds the input side off.
// Configuration: i_cfg_we writes max_payload; the user must write it only
// while idle, and the block itself does not enforce this.
// Reset (synchronous, active low) empties the store, clears the counters
// and sets max_payload to 59. Store contents are not cleared.
// ----------------------------------------------------------------------------
module magic_len_crc16_frame_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_max_payload,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_payload_byte,
    output logic        o_last,
    output logic [5:0]  o_payload_length,
    output logic [31:0] o_noise_total,
    output logic [31:0] o_bad_length_total,
    output logic [31:0] o_bad_crc_total,
    output logic [31:0] o_good_frame_total
);
    import mlcfd_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN_START, ST_SCAN_RD, ST_SCAN_CK, ST_LEN_RD, ST_LEN_CK,
        ST_CRC_RD, ST_CRC_CK, ST_RXL_RD, ST_RXL_CK, ST_RXH_RD, ST_RXH_CK,
        ST_EMIT, ST_PAY_RD, ST_PAY_CK
    } t_state;

    t_state             r_state, n_state;
    logic [ADDR_W-1:0]  r_head, n_head;
    logic [FILL_W-1:0]  r_fill, n_fill;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic               r_pa5, n_pa5;
    logic [7:0]         r_len, n_len;
    logic [15:0]        r_crc, n_crc;
    logic [7:0]         r_rx_lo, n_rx_lo;
    t_kind              r_kind, n_kind;
    logic [5:0]         r_max, n_max;
    logic [31:0]        r_noise, n_noise, r_badlen, n_badlen;
    logic [31:0]        r_badcrc, n_badcrc, r_good, n_good;

    logic               r_ov, n_ov;
    t_kind              r_okind, n_okind;
    logic [7:0]         r_obyte, n_obyte;
    logic               r_olast, n_olast;
    logic [5:0]         r_olen, n_olen;
    logic [31:0]        r_onoise, n_onoise, r_obadlen, n_obadlen;
    logic [31:0]        r_obadcrc, n_obadcrc, r_ogood, n_ogood;

    logic               store_we;
    logic [ADDR_W-1:0]  waddr, raddr;
    logic [7:0]         rdata;
    logic               slot_free;
    logic [IDX_W-1:0]   fill_x, len_x, limit_x, disc_x;
    logic [FILL_W-1:0]  disc;
    logic               load_out;

    mlcfd_store u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (waddr),
        .i_wdata (i_data_byte),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign waddr    = wrap_add(r_head, r_fill);
    assign raddr    = wrap_add(r_head, r_idx[FILL_W-1:0]);
    assign store_we = (r_state == ST_IDLE) && i_valid &&
                      (r_fill < FILL_W'(BUFFER_BYTES));
    assign slot_free = !r_ov || !i_stall;
    assign fill_x   = IDX_W'(r_fill);
    assign len_x    = IDX_W'(r_len);
    assign limit_x  = (IDX_W'(r_max) > IDX_W'(LEN_CAP)) ? IDX_W'(LEN_CAP)
                                                        : IDX_W'(r_max);

    always_comb begin
        n_state  = r_state;   n_head   = r_head;   n_fill  = r_fill;
        n_idx    = r_idx;     n_pa5    = r_pa5;    n_len   = r_len;
        n_crc    = r_crc;     n_rx_lo  = r_rx_lo;  n_kind  = r_kind;
        n_max    = r_max;     n_noise  = r_noise;  n_badlen = r_badlen;
        n_badcrc = r_badcrc;  n_good   = r_good;
        n_ov     = r_ov && i_stall;
        n_okind  = r_okind;   n_obyte  = r_obyte;  n_olast = r_olast;
        n_olen   = r_olen;
        n_onoise = r_onoise;  n_obadlen = r_obadlen;
        n_obadcrc = r_obadcrc; n_ogood = r_ogood;
        disc_x   = '0;
        disc     = '0;
        load_out = 1'b0;

        if (i_cfg_we) begin
            n_max = i_cfg_max_payload;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (store_we) n_fill = r_fill + 1'b1;
                    n_state = ST_SCAN_START;
                end
            end
            ST_SCAN_START: begin
                n_idx = '0;
                n_pa5 = 1'b0;
                n_state = (r_fill == '0) ? ST_IDLE : ST_SCAN_RD;
            end
            ST_SCAN_RD: n_state = ST_SCAN_CK;
            ST_SCAN_CK: begin
                if (r_pa5 && rdata == MAGIC_SECOND) begin
                    // magic starts one byte back
                    disc_x  = r_idx - 1'b1;
                    disc    = disc_x[FILL_W-1:0];
                    n_head  = wrap_add(r_head, disc);
                    n_fill  = r_fill - disc;
                    n_noise = r_noise + 32'(disc);
                    if (fill_x - disc_x < IDX_W'(HEADER_LEN)) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = IDX_W'(2);
                        n_state = ST_LEN_RD;
                    end
                end else begin
                    n_pa5 = (rdata == MAGIC_FIRST);
                    if (r_idx + 1'b1 == fill_x) begin
                        // no magic: keep a trailing A5
                        disc    = (rdata == MAGIC_FIRST) ? r_fill - 1'b1 : r_fill;
                        n_head  = wrap_add(r_head, disc);
                        n_fill  = r_fill - disc;
                        n_noise = r_noise + 32'(disc);
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = ST_SCAN_RD;
                    end
                end
            end
            ST_LEN_RD: n_state = ST_LEN_CK;
            ST_LEN_CK: begin
                n_len = rdata;
                if (IDX_W'(rdata) > limit_x) begin
                    n_badlen = r_badlen + 1'b1;
                    n_head   = wrap_add(r_head, FILL_W'(1));
                    n_fill   = r_fill - 1'b1;
                    n_kind   = KIND_BAD_LEN;
                    n_state  = ST_EMIT;
                end else if (fill_x < IDX_W'(rdata) + IDX_W'(HEADER_LEN + CRC_LEN)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_crc   = CRC_INIT;
                    n_state = ST_CRC_RD;
                end
            end
            ST_CRC_RD: n_state = ST_CRC_CK;
            ST_CRC_CK: begin
                n_crc = crc_byte(r_crc, rdata);
                n_idx = r_idx + 1'b1;
                n_state = (r_idx == len_x + IDX_W'(2)) ? ST_RXL_RD : ST_CRC_RD;
            end
            ST_RXL_RD: n_state = ST_RXL_CK;
            ST_RXL_CK: begin
                n_rx_lo = rdata;
                n_idx   = r_idx + 1'b1;
                n_state = ST_RXH_RD;
            end
            ST_RXH_RD: n_state = ST_RXH_CK;
            ST_RXH_CK: begin
                if ({rdata, r_rx_lo} != r_crc) begin
                    n_badcrc = r_badcrc + 1'b1;
                    n_head   = wrap_add(r_head, FILL_W'(1));
                    n_fill   = r_fill - 1'b1;
                    n_kind   = KIND_BAD_CRC;
                    n_state  = ST_EMIT;
                end else begin
                    n_good = r_good + 1'b1;
                    if (r_len == 8'd0) begin
                        disc    = FILL_W'(HEADER_LEN + CRC_LEN);
                        n_head  = wrap_add(r_head, disc);
                        n_fill  = r_fill - disc;
                        n_kind  = KIND_EMPTY;
                        n_state = ST_EMIT;
                    end else begin
                        n_idx   = IDX_W'(HEADER_LEN);
                        n_state = ST_PAY_RD;
                    end
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    load_out = 1'b1;
                    n_okind  = r_kind;
                    n_obyte  = 8'd0;
                    n_olast  = 1'b1;
                    n_olen   = 6'd0;
                    n_state  = ST_SCAN_START;
                end
            end
            ST_PAY_RD: n_state = ST_PAY_CK;
            ST_PAY_CK: begin
                if (slot_free) begin
                    load_out = 1'b1;
                    n_okind  = KIND_PAYLOAD;
                    n_obyte  = rdata;
                    n_olast  = (r_idx == len_x + IDX_W'(2));
                    n_olen   = r_len[5:0];
                    if (r_idx == len_x + IDX_W'(2)) begin
                        disc_x  = len_x + IDX_W'(HEADER_LEN + CRC_LEN);
                        disc    = disc_x[FILL_W-1:0];
                        n_head  = wrap_add(r_head, disc);
                        n_fill  = r_fill - disc;
                        n_state = ST_SCAN_START;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = ST_PAY_RD;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (load_out) begin
            n_ov      = 1'b1;
            n_onoise  = r_noise;
            n_obadlen = r_badlen;
            n_obadcrc = r_badcrc;
            n_ogood   = r_good;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_head   <= '0;
            r_fill   <= '0;
            r_max    <= MAX_PAYLOAD_RST;
            r_noise  <= '0;
            r_badlen <= '0;
            r_badcrc <= '0;
            r_good   <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_fill   <= n_fill;
            r_max    <= n_max;
            r_noise  <= n_noise;
            r_badlen <= n_badlen;
            r_badcrc <= n_badcrc;
            r_good   <= n_good;
            r_ov     <= n_ov;
        end
        r_idx     <= n_idx;
        r_pa5     <= n_pa5;
        r_len     <= n_len;
        r_crc     <= n_crc;
        r_rx_lo   <= n_rx_lo;
        r_kind    <= n_kind;
        r_okind   <= n_okind;
        r_obyte   <= n_obyte;
        r_olast   <= n_olast;
        r_olen    <= n_olen;
        r_onoise  <= n_onoise;
        r_obadlen <= n_obadlen;
        r_obadcrc <= n_obadcrc;
        r_ogood   <= n_ogood;
    end

    assign o_stall            = (r_state != ST_IDLE);
    assign o_valid            = r_ov;
    assign o_kind             = r_okind;
    assign o_payload_byte     = r_obyte;
    assign o_last             = r_olast;
    assign o_payload_length   = r_olen;
    assign o_noise_total      = r_onoise;
    assign o_bad_length_total = r_obadlen;
    assign o_bad_crc_total    = r_obadcrc;
    assign o_good_frame_total = r_ogood;

endmodule

// ===== rtl/mlcfd_checker.sv =====
// ----------------------------------------------------------------------------
// mlcfd_checker
// Port-level checks on the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module mlcfd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_kind,
    input logic [7:0]  o_payload_byte,
    input logic        o_last,
    input logic [5:0]  o_payload_length
);
    import mlcfd_pkg::*;

    // a transfer in makes the block busy in the next cycle
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input side ready right after a transfer");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_payload_byte))
        else $error("stalled result changed");

    a_event_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind != KIND_PAYLOAD) |->
            o_last && o_payload_byte == 8'd0 && o_payload_length == 6'd0)
        else $error("event item malformed");

    a_payload_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_PAYLOAD) |-> o_payload_length != 6'd0)
        else $error("payload item with zero length");

endmodule

bind magic_len_crc16_frame_deframer mlcfd_checker u_mlcfd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_stall          (o_stall),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_kind           (o_kind),
    .o_payload_byte   (o_payload_byte),
    .o_last           (o_last),
    .o_payload_length (o_payload_length)
);
